@@ rtl/vwsc_pkg.sv @@
// Package for the window variance stall counter.
// Holds the shared widths, register codes and pipeline load struct.
// No dependencies.
`timescale 1ns / 1ps

package vwsc_pkg;

  // Field widths of one item and of one result.
  localparam int SAMPLE_W = 16;
  localparam int COUNT_W  = 16;
  localparam int SUM_W    = 24;
  localparam int SQSUM_W  = 40;
  localparam int THR_W    = 32;

  // Width of both sides of the variance compare; covers the largest window.
  localparam int CMP_W = 56;

  // Register map.
  localparam logic REG_VARIANCE_THRESHOLD = 1'b0;
  localparam logic [THR_W-1:0] THRESHOLD_RESET = 32'd16;

  localparam logic [COUNT_W-1:0] COUNT_MAX = 16'hFFFF;

  // Load strobes of the five pipeline registers.
  typedef struct packed {
    logic ld1;  // accepted item into the input register
    logic ld2;  // deltas
    logic ld3;  // running sums
    logic ld4;  // products
    logic ld5;  // result register
  } pipe_ld_t;

endpackage

@@ rtl/window_variance_stall_counter_core.sv @@
// Window variance stall counter: top level with configuration port and flow control.
// Depends on vwsc_pkg, vwsc_window, vwsc_accum and vwsc_detect.
`timescale 1ns / 1ps

// One signed sample is taken per item and replaces the oldest of WINDOW_DEPTH
// samples; each item gives one result with the stall counter, the
// variance-high flag and the window sum. The block takes one item every clock
// cycle while in_stall is low, and each item passes five registers on its way
// to a result: an input register, a squaring stage, the running-sum
// accumulators, a product stage and the compare with the result register. The
// rate is set by the two feedback loops, the running-sum add and the stall
// counter. The window lives in a memory with one write and one registered read
// port; the entry to be replaced is fetched while the previous item is written,
// and a fill flag makes never-written entries read as zero, so no clearing pass
// runs after reset. A pipeline stage holding no item does not block the one
// before it, so items can still enter while a result waits. variance_threshold
// sits at byte address 0 in units of 1/16; it must be written only while the
// block is idle, which the block itself does not enforce.
module window_variance_stall_counter_core #(
  parameter int WINDOW_DEPTH = 16
) (
  input  logic                                 clk,
  input  logic                                 rst,
  // input channel
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic signed [vwsc_pkg::SAMPLE_W-1:0] sample,
  // result channel
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic        [vwsc_pkg::COUNT_W-1:0]  blocked_count,
  output logic                                 variance_high,
  output logic signed [vwsc_pkg::SUM_W-1:0]    window_sum,
  // configuration port
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic        [2:0]                    paddr,
  input  logic        [31:0]                   pwdata,
  output logic        [31:0]                   prdata,
  output logic                                 pready
);

  localparam logic [vwsc_pkg::CMP_W-1:0] NN =
    vwsc_pkg::CMP_W'(WINDOW_DEPTH * WINDOW_DEPTH);
  localparam logic [vwsc_pkg::CMP_W-1:0] THR_SCALED_RESET =
    vwsc_pkg::CMP_W'(vwsc_pkg::THRESHOLD_RESET) * NN;

  logic [vwsc_pkg::THR_W-1:0] threshold;
  logic [vwsc_pkg::CMP_W-1:0] thr_scaled;
  logic                       cfg_wr;

  logic v1, v2, v3, v4;
  logic rdy1, rdy2, rdy3, rdy4, rdy5;
  vwsc_pkg::pipe_ld_t ld;

  logic signed [vwsc_pkg::SAMPLE_W-1:0] old;
  logic signed [vwsc_pkg::SUM_W-1:0]    sum;
  logic        [vwsc_pkg::SQSUM_W-1:0]  sqsum;

  // Configuration register, kept with its scaled copy for the compare.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready &&
                  (paddr[2] == vwsc_pkg::REG_VARIANCE_THRESHOLD);

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold  <= vwsc_pkg::THRESHOLD_RESET;
      thr_scaled <= THR_SCALED_RESET;
    end else if (cfg_wr) begin
      threshold  <= pwdata;
      thr_scaled <= vwsc_pkg::CMP_W'(pwdata) * NN;
    end
  end

  assign prdata = (paddr[2] == vwsc_pkg::REG_VARIANCE_THRESHOLD) ? threshold : '0;

  // A stage may load when it is empty or its item moves on.
  assign rdy5 = !out_valid || !out_stall;
  assign rdy4 = !v4 || rdy5;
  assign rdy3 = !v3 || rdy4;
  assign rdy2 = !v2 || rdy3;
  assign rdy1 = !v1 || rdy2;

  assign in_stall = !rdy1;
  assign ld.ld1   = in_valid && rdy1;
  assign ld.ld2   = v1 && rdy2;
  assign ld.ld3   = v2 && rdy3;
  assign ld.ld4   = v3 && rdy4;
  assign ld.ld5   = v4 && rdy5;

  // Advance the valid bits along the pipeline.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      v4        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (rdy1) v1 <= in_valid;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
      if (rdy4) v4 <= v3;
      if (rdy5) out_valid <= v4;
    end
  end

  vwsc_window #(
    .WINDOW_DEPTH (WINDOW_DEPTH)
  ) u_window (
    .clk     (clk),
    .rst     (rst),
    .ld      (ld),
    .wr_data (sample),
    .old     (old)
  );

  vwsc_accum u_accum (
    .clk       (clk),
    .rst       (rst),
    .ld        (ld),
    .sample_in (sample),
    .old_in    (old),
    .sum       (sum),
    .sqsum     (sqsum)
  );

  vwsc_detect #(
    .WINDOW_DEPTH (WINDOW_DEPTH)
  ) u_detect (
    .clk           (clk),
    .rst           (rst),
    .ld            (ld),
    .sum           (sum),
    .sqsum         (sqsum),
    .thr_scaled    (thr_scaled),
    .blocked_count (blocked_count),
    .variance_high (variance_high),
    .window_sum    (window_sum)
  );

endmodule

@@ rtl/vwsc_window.sv @@
// Ring window of samples kept in a memory, with the oldest entry prefetched.
// Depends on vwsc_pkg.
`timescale 1ns / 1ps

module vwsc_window #(
  parameter int WINDOW_DEPTH = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  vwsc_pkg::pipe_ld_t                  ld,
  input  logic signed [vwsc_pkg::SAMPLE_W-1:0] wr_data,
  output logic signed [vwsc_pkg::SAMPLE_W-1:0] old
);

  localparam int AW = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam logic [AW-1:0] LAST = AW'(WINDOW_DEPTH - 1);

  logic signed [vwsc_pkg::SAMPLE_W-1:0] mem [WINDOW_DEPTH];
  logic signed [vwsc_pkg::SAMPLE_W-1:0] rd_data;
  logic [AW-1:0] pos;
  logic [AW-1:0] pos_next;
  logic          filled;

  // Advance the write position, wrapping at the window depth.
  assign pos_next = (pos == LAST) ? '0 : pos + 1'b1;

  // Until the first wrap the oldest entry was never written: it reads as zero.
  assign old = filled ? rd_data : '0;

  // Write the new sample and prefetch the entry the next item will replace.
  always_ff @(posedge clk) begin
    if (ld.ld1) begin
      mem[pos] <= wr_data;
      rd_data  <= mem[pos_next];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos    <= '0;
      filled <= 1'b0;
    end else if (ld.ld1) begin
      pos <= pos_next;
      if (pos == LAST) begin
        filled <= 1'b1;
      end
    end
  end

endmodule

@@ rtl/vwsc_accum.sv @@
// Square the incoming and outgoing samples and keep the running sums.
// Depends on vwsc_pkg.
`timescale 1ns / 1ps

module vwsc_accum (
  input  logic                                 clk,
  input  logic                                 rst,
  input  vwsc_pkg::pipe_ld_t                   ld,
  input  logic signed [vwsc_pkg::SAMPLE_W-1:0] sample_in,
  input  logic signed [vwsc_pkg::SAMPLE_W-1:0] old_in,
  output logic signed [vwsc_pkg::SUM_W-1:0]    sum,
  output logic        [vwsc_pkg::SQSUM_W-1:0]  sqsum
);

  logic signed [vwsc_pkg::SAMPLE_W-1:0] new_r;
  logic signed [vwsc_pkg::SAMPLE_W-1:0] old_r;
  logic signed [31:0] new_sq;
  logic signed [31:0] old_sq;
  logic signed [16:0] dsum;
  logic signed [32:0] dsq;

  // Capture the accepted sample with the one it displaces.
  always_ff @(posedge clk) begin
    if (ld.ld1) begin
      new_r <= sample_in;
      old_r <= old_in;
    end
  end

  assign new_sq = new_r * new_r;
  assign old_sq = old_r * old_r;

  // Register the change to both sums.
  always_ff @(posedge clk) begin
    if (ld.ld2) begin
      dsum <= 17'(new_r) - 17'(old_r);
      dsq  <= 33'(new_sq) - 33'(old_sq);
    end
  end

  // Apply the change; the sum of squares never goes negative.
  always_ff @(posedge clk) begin
    if (rst) begin
      sum   <= '0;
      sqsum <= '0;
    end else if (ld.ld3) begin
      sum   <= sum + vwsc_pkg::SUM_W'(dsum);
      sqsum <= sqsum + vwsc_pkg::SQSUM_W'(dsq);
    end
  end

endmodule

@@ rtl/vwsc_detect.sv @@
// Variance compare and saturating stall counter feeding the result register.
// Depends on vwsc_pkg.
`timescale 1ns / 1ps

module vwsc_detect #(
  parameter int WINDOW_DEPTH = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  vwsc_pkg::pipe_ld_t                  ld,
  input  logic signed [vwsc_pkg::SUM_W-1:0]   sum,
  input  logic        [vwsc_pkg::SQSUM_W-1:0] sqsum,
  input  logic        [vwsc_pkg::CMP_W-1:0]   thr_scaled,
  output logic        [vwsc_pkg::COUNT_W-1:0] blocked_count,
  output logic                                variance_high,
  output logic signed [vwsc_pkg::SUM_W-1:0]   window_sum
);

  localparam logic [vwsc_pkg::CMP_W-1:0] N_C = vwsc_pkg::CMP_W'(WINDOW_DEPTH);

  logic signed [2*vwsc_pkg::SUM_W-1:0] sum_sq;
  logic        [vwsc_pkg::CMP_W-1:0]   nsq;
  logic        [vwsc_pkg::CMP_W-1:0]   sum2;
  logic signed [vwsc_pkg::SUM_W-1:0]   sum_r;
  logic        [vwsc_pkg::CMP_W-1:0]   lhs;
  logic                                high;

  assign sum_sq = sum * sum;

  // Register N times the sum of squares and the square of the sum.
  always_ff @(posedge clk) begin
    if (ld.ld4) begin
      nsq   <= vwsc_pkg::CMP_W'(sqsum) * N_C;
      sum2  <= vwsc_pkg::CMP_W'($unsigned(sum_sq));
      sum_r <= sum;
    end
  end

  // 16*(N*sqsum - sum^2) against threshold*N*N; equal counts as not above.
  assign lhs  = (nsq - sum2) << 4;
  assign high = lhs > thr_scaled;

  // Clear on high variance, else count up and hold at the top.
  always_ff @(posedge clk) begin
    if (rst) begin
      blocked_count <= '0;
    end else if (ld.ld5) begin
      if (high) begin
        blocked_count <= '0;
      end else if (blocked_count != vwsc_pkg::COUNT_MAX) begin
        blocked_count <= blocked_count + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ld.ld5) begin
      variance_high <= high;
      window_sum    <= sum_r;
    end
  end

endmodule

@@ rtl/vwsc_checker.sv @@
// Port-level checks for the window variance stall counter, bound to the top level.
// Depends on vwsc_pkg and window_variance_stall_counter_core.
`timescale 1ns / 1ps

module vwsc_checker (
  input logic                                 clk,
  input logic                                 rst,
  input logic                                 out_valid,
  input logic                                 out_stall,
  input logic        [vwsc_pkg::COUNT_W-1:0]  blocked_count,
  input logic                                 variance_high,
  input logic signed [vwsc_pkg::SUM_W-1:0]    window_sum
);

  // No result is shown right after reset.
  a_reset_clears: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  // High variance always comes with a cleared counter.
  a_high_clears: assert property (@(posedge clk) disable iff (rst)
    out_valid && variance_high |-> blocked_count == '0)
    else $error("counter not cleared on high variance");

  // A quiet sample always leaves a nonzero count.
  a_quiet_counts: assert property (@(posedge clk) disable iff (rst)
    out_valid && !variance_high |-> blocked_count != '0)
    else $error("counter zero on quiet sample");

  // Back-to-back results: a quiet one steps the counter by one, holding at the top.
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall) ##1 (out_valid && !variance_high) |->
      ((($past(blocked_count) == vwsc_pkg::COUNT_MAX) &&
        (blocked_count == vwsc_pkg::COUNT_MAX)) ||
       (($past(blocked_count) != vwsc_pkg::COUNT_MAX) &&
        (blocked_count == $past(blocked_count) + 1'b1))))
    else $error("counter did not step by one");

  // A stalled result holds.
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(window_sum) &&
      $stable(blocked_count) && $stable(variance_high))
    else $error("stalled result changed");

endmodule

bind window_variance_stall_counter_core vwsc_checker u_vwsc_checker (.*);

@@ tb/testbench.sv @@
// Self-checking testbench for window_variance_stall_counter_core.
// Depends on vwsc_pkg and the core; predicts every result from an in-bench
// copy of the sample window, running sums and stall counter.
`timescale 1ns / 1ps

module testbench;

  localparam int WINDOW_N = 16;
  localparam int DRAIN_CYCLES = 12;
  localparam int MAX_REPORTS = 20;
  localparam int QUIET_ITEMS = 40;

  // Byte addresses of the register map; index 1 maps to no register.
  localparam logic REG_UNMAPPED = 1'b1;
  localparam logic [2:0] THRESHOLD_ADDR = {vwsc_pkg::REG_VARIANCE_THRESHOLD, 2'b00};
  localparam logic [2:0] UNMAPPED_ADDR = {REG_UNMAPPED, 2'b00};

  typedef struct {
    logic [vwsc_pkg::COUNT_W-1:0] count;
    logic high;
    logic signed [vwsc_pkg::SUM_W-1:0] sum;
  } window_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [vwsc_pkg::SAMPLE_W-1:0] sample = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [vwsc_pkg::COUNT_W-1:0] blocked_count;
  logic variance_high;
  logic signed [vwsc_pkg::SUM_W-1:0] window_sum;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  // Shadow state of the block
  logic signed [vwsc_pkg::SAMPLE_W-1:0] window_shadow [WINDOW_N] = '{default: '0};
  int write_slot = 0;
  logic signed [vwsc_pkg::SUM_W-1:0] sum_shadow = '0;
  logic [vwsc_pkg::SQSUM_W-1:0] square_sum_shadow = '0;
  logic [vwsc_pkg::COUNT_W-1:0] hold_count_shadow = '0;
  logic [vwsc_pkg::THR_W-1:0] threshold_shadow = vwsc_pkg::THRESHOLD_RESET;

  logic signed [vwsc_pkg::SAMPLE_W-1:0] sample_queue [$];
  window_result_t expected_results [$];

  logic in_accepted = 1'b0;
  logic out_accepted = 1'b0;
  int send_gap = 0;
  bit send_steady = 1'b0;
  int recv_wait = 0;
  bit recv_steady = 1'b0;

  int mismatch_count = 0;
  int results_checked = 0;
  int samples_sent = 0;
  int threshold_writes = 0;
  int saturated_results = 0;
  int cleared_results = 0;

  window_variance_stall_counter_core #(
    .WINDOW_DEPTH(WINDOW_N)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .sample(sample),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .blocked_count(blocked_count),
    .variance_high(variance_high),
    .window_sum(window_sum),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // Advance the window by one sample and return the result it should produce
  function automatic window_result_t predict_window_step(
    input logic signed [vwsc_pkg::SAMPLE_W-1:0] s);
    logic signed [vwsc_pkg::SAMPLE_W-1:0] oldest;
    longint sum_l;
    longint spread;
    longint limit;
    window_result_t r;
    oldest = window_shadow[write_slot];
    window_shadow[write_slot] = s;
    write_slot = (write_slot == WINDOW_N - 1) ? 0 : write_slot + 1;
    sum_shadow = sum_shadow - oldest + s;
    square_sum_shadow = square_sum_shadow
                        - vwsc_pkg::SQSUM_W'(longint'(oldest) * oldest)
                        + vwsc_pkg::SQSUM_W'(longint'(s) * s);
    // Exact integer form of: variance > threshold / 16
    sum_l = sum_shadow;
    spread = 16 * (WINDOW_N * longint'(square_sum_shadow) - sum_l * sum_l);
    limit = longint'({32'd0, threshold_shadow}) * WINDOW_N * WINDOW_N;
    r.high = spread > limit;
    if (r.high) begin
      hold_count_shadow = '0;
    end else if (hold_count_shadow != vwsc_pkg::COUNT_MAX) begin
      hold_count_shadow = hold_count_shadow + 1'b1;
    end
    r.count = hold_count_shadow;
    r.sum = sum_shadow;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) begin
      $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    end
  endtask

  // Sample both channels; check the oldest expectation, then predict the new item
  always @(posedge clk) begin
    window_result_t want;
    in_accepted <= !rst && in_valid && !in_stall;
    out_accepted <= !rst && out_valid && !out_stall;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result count", blocked_count, -1);
        end else begin
          want = expected_results.pop_front();
          results_checked++;
          if (blocked_count !== want.count) begin
            report_mismatch("blocked_count", blocked_count, want.count);
          end
          if (variance_high !== want.high) begin
            report_mismatch("variance_high", variance_high, want.high);
          end
          if (window_sum !== want.sum) begin
            report_mismatch("window_sum", longint'(window_sum), longint'(want.sum));
          end
          if (want.count == vwsc_pkg::COUNT_MAX) saturated_results++;
          if (want.high) cleared_results++;
        end
      end
      if (in_valid && !in_stall) begin
        expected_results.push_back(predict_window_step(sample));
        samples_sent++;
      end
    end
  end

  // Sample driver: hold the item until taken, then wait the drawn gap
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_accepted) begin
      if (send_gap > 0) begin
        in_valid <= 1'b0;
        send_gap--;
      end else if (sample_queue.size() > 0) begin
        sample <= sample_queue.pop_front();
        in_valid <= 1'b1;
        if ($urandom_range(0, 31) == 0) send_steady = !send_steady;
        send_gap = send_steady ? 0 : int'($urandom_range(0, 3));
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result receiver: stall a drawn number of cycles after each item
  always @(negedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_accepted) begin
        if ($urandom_range(0, 31) == 0) recv_steady = !recv_steady;
        recv_wait = recv_steady ? 0 : int'($urandom_range(0, 3));
      end
      if (recv_wait > 0) begin
        out_stall <= 1'b1;
        recv_wait--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (addr == THRESHOLD_ADDR) begin
      threshold_shadow = data;
      threshold_writes++;
    end
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic check_threshold_readback();
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= THRESHOLD_ADDR;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== threshold_shadow) begin
      report_mismatch("variance_threshold readback", prdata, threshold_shadow);
    end
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  // Hold until every queued item is taken and every result has come back
  task automatic wait_for_drain();
    while (sample_queue.size() != 0 || in_valid || expected_results.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Queue bursts of samples: mostly noise around a baseline, some wide or extreme.
  // Quiet mode keeps the amplitude tiny so the variance stays low.
  task automatic queue_random_items(input int count, input bit quiet);
    int pushed;
    int burst;
    int base;
    int amp;
    int v;
    int kind;
    pushed = 0;
    while (pushed < count) begin
      burst = int'($urandom_range(16, 48));
      kind = quiet ? 0 : int'($urandom_range(0, 9));
      base = int'($urandom_range(0, 60000)) - 30000;
      case ($urandom_range(0, 2))
        0: amp = 0;
        1: amp = int'($urandom_range(1, 8));
        default: amp = quiet ? 4 : int'($urandom_range(9, 128));
      endcase
      if (quiet && amp > 4) amp = 4;
      for (int i = 0; i < burst && pushed < count; i++) begin
        if (kind <= 6) begin
          v = base + int'($urandom_range(0, 2 * amp)) - amp;
          if (v > 32767) v = 32767;
          if (v < -32768) v = -32768;
          sample_queue.push_back(vwsc_pkg::SAMPLE_W'(v));
        end else if (kind <= 8) begin
          sample_queue.push_back(vwsc_pkg::SAMPLE_W'($urandom));
        end else begin
          case ($urandom_range(0, 3))
            0: sample_queue.push_back(16'sh7FFF);
            1: sample_queue.push_back(16'sh8000);
            2: sample_queue.push_back(16'sh0000);
            default: sample_queue.push_back(16'shFFFF);
          endcase
        end
        pushed++;
      end
    end
  endtask

  task automatic run_random_phase(input logic [31:0] threshold, input int count);
    wait_for_drain();
    apb_write(THRESHOLD_ADDR, threshold);
    check_threshold_readback();
    queue_random_items(count, 1'b0);
  endtask

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset value of the threshold, then extremes at the reset threshold
    check_threshold_readback();
    sample_queue.push_back(16'sh0000);
    sample_queue.push_back(16'sh7FFF);
    sample_queue.push_back(16'sh8000);
    sample_queue.push_back(16'shFFFF);
    sample_queue.push_back(16'sh0001);
    sample_queue.push_back(16'sh5555);
    sample_queue.push_back(16'shAAAA);

    // Flat window, then one step of 4 gives variance exactly 15/16: equal, not above
    for (int i = 0; i < WINDOW_N; i++) sample_queue.push_back(16'sd7);
    wait_for_drain();
    apb_write(THRESHOLD_ADDR, 32'd15);
    sample_queue.push_back(16'sd11);
    sample_queue.push_back(16'sd11);

    // Random phases over several thresholds, extremes included
    run_random_phase(32'd800, 300);
    run_random_phase(32'd0, 300);
    run_random_phase(32'hFFFF_FFFF, 300);
    run_random_phase(32'd9600, 300);

    // A write to an unmapped index must leave the threshold alone
    wait_for_drain();
    apb_write(UNMAPPED_ADDR, $urandom);
    check_threshold_readback();

    run_random_phase($urandom, 300);
    run_random_phase(32'd48000, 300);

    // Quiet samples under the largest threshold keep the counter climbing
    wait_for_drain();
    apb_write(THRESHOLD_ADDR, 32'hFFFF_FFFF);
    queue_random_items(QUIET_ITEMS, 1'b1);

    // Zero threshold: a flat window still counts, any spread clears
    wait_for_drain();
    apb_write(THRESHOLD_ADDR, 32'd0);
    for (int i = 0; i < WINDOW_N + 4; i++) sample_queue.push_back(16'sh1234);
    sample_queue.push_back(16'sh1235);
    sample_queue.push_back(16'sh1234);

    wait_for_drain();
    if (expected_results.size() != 0) begin
      report_mismatch("results never received", expected_results.size(), 0);
    end
    $display("Run covered %0d samples and %0d checked results under %0d threshold writes,",
             samples_sent, results_checked, threshold_writes);
    $display("with %0d saturated counter results and %0d variance-high clears.",
             saturated_results, cleared_results);
    if (mismatch_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Run limit, several times the slowest correct run
  initial begin
    #4_000_000;
    $display("Timeout with %0d results still expected", expected_results.size());
    $display("FAILED: results differ");
    $finish;
  end

endmodule
